// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the 1-Wire bus master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define OWM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define OWM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define OWM_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/owm_pkg.sv
// Types, codes and constants of the 1-Wire bus master.
`default_nettype none
package owm_pkg;

  // Defaults of the top level parameters.
  localparam int TIMER_BITS_DEF     = 10;
  localparam int READ_LOW_US_DEF    = 1;
  localparam int READ_SAMPLE_US_DEF = 5;

  localparam int CFG_W     = 10;
  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] SKIP_ROM = 8'hCC;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW      = 3'd0,
    CFG_PRESENCE_WIN   = 3'd1,
    CFG_RELEASE_WAIT   = 3'd2,
    CFG_WRITE_ONE_LOW  = 3'd3,
    CFG_WRITE_ONE_HIGH = 3'd4,
    CFG_WRITE_ZERO_LOW = 3'd5,
    CFG_WRITE_ZERO_HIGH = 3'd6,
    CFG_READ_RECOVERY  = 3'd7
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL [CFG_NUM] = '{
    10'd480, 10'd60, 10'd450, 10'd10, 10'd55, 10'd65, 10'd5, 10'd60
  };

  // Request codes carried by an input beat.
  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_RESET = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_READ  = 3'd3,
    REQ_BCAST = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_BUSY      = 3'd1,
    ST_BYTE_DONE = 3'd2,
    ST_DONE      = 3'd3,
    ST_NO_PULLUP = 3'd4,
    ST_NO_DEVICE = 3'd5,
    ST_TIMEOUT   = 3'd6
  } status_e;

  // Kind of operation in progress.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_BCAST = 3'd4
  } op_e;

  // Stage of a broadcast sequence.
  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_SKIP  = 2'd1,
    CMD_BYTE  = 2'd2
  } cmd_stage_e;

  // Result beat payload.
  typedef struct packed {
    logic       drive_low;
    logic [2:0] status;
    logic [7:0] rx_byte;
    logic       rx_valid;
  } out_item_t;

  // Zero durations that need at least one tick count as one.
  function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
    return (v == '0) ? CFG_W'(1) : v;
  endfunction

endpackage
`default_nettype wire

// File: sv/owm_if.sv
// Channel interfaces of the 1-Wire bus master: tick input, result output, config write.
`default_nettype none
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic       line_level;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, req_type, line_level, tx_byte, last_byte, input ready);
  modport sink   (input valid, req_type, line_level, tx_byte, last_byte, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic [2:0] status;
  logic [7:0] rx_byte;
  logic       rx_valid;
  modport source (output valid, drive_low, status, rx_byte, rx_valid, input ready);
  modport sink   (input valid, drive_low, status, rx_byte, rx_valid, output ready);
endinterface

interface owm_cfg_if;
  import owm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/onewire_bus_master.sv
// Top level of the 1-Wire bus master: timing sequencer, config registers, result register.
//
// Channel   Dir  Beat contents
// in_i      in   one 1 us tick: req_type, line_level, tx_byte, last_byte
// out_o     out  one result per tick: drive_low, status, rx_byte, rx_valid
// cfg_i     in   register index and 10-bit duration
//
// A new tick is accepted each cycle while no held result stalls the input.
// The sequencer state and the result register both update on the accepting edge.
// A result waiting in the output register does not block input while out_o.ready is high.
// With out_o.ready low a held result blocks input until it is taken.
// Reset restores the idle phase and the default timing registers; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module onewire_bus_master #(
  parameter int TIMER_BITS     = owm_pkg::TIMER_BITS_DEF,
  parameter int READ_LOW_US    = owm_pkg::READ_LOW_US_DEF,
  parameter int READ_SAMPLE_US = owm_pkg::READ_SAMPLE_US_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  owm_in_if.sink      in_i,
  owm_out_if.source   out_o,
  owm_cfg_if.sink     cfg_i
);
  import owm_pkg::*;

  // Sequencer phases, one-hot.
  typedef enum logic [9:0] {
    PH_IDLE     = 10'b0000000001,
    PH_RST_LOW  = 10'b0000000010,
    PH_PRES     = 10'b0000000100,
    PH_REL_WAIT = 10'b0000001000,
    PH_REL_HOLD = 10'b0000010000,
    PH_W_LOW    = 10'b0000100000,
    PH_W_HIGH   = 10'b0001000000,
    PH_R_LOW    = 10'b0010000000,
    PH_R_WAIT   = 10'b0100000000,
    PH_R_REC    = 10'b1000000000
  } phase_e;

  localparam logic [TIMER_BITS-1:0] READ_LOW_T =
      TIMER_BITS'((READ_LOW_US > 0) ? READ_LOW_US : 1);
  localparam logic [TIMER_BITS-1:0] READ_WAIT_T = TIMER_BITS'(READ_SAMPLE_US + 1);

  logic [CFG_W-1:0] cfg_q [CFG_NUM];

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_dec;
  logic                  timer_zero;
  logic [7:0]            shift_q, shift_d;
  logic [3:0]            bit_count_q, bit_count_d;
  op_e                   op_kind_q, op_kind_d;
  logic                  last_q, last_d;
  logic [7:0]            cmd_hold_q, cmd_hold_d;
  cmd_stage_e            cmd_stage_q, cmd_stage_d;

  logic       out_valid_q;
  out_item_t  out_q, res;
  logic       in_acc;

  // Events raised by a phase and resolved after the phase logic.
  logic       ev_reset_done, ev_wbit_done, ev_rbit_done, ev_byte_written;
  logic       ev_start_write, ev_load_write, ev_finish;
  logic [7:0] start_byte;
  status_e    fin_status;
  logic [CFG_W-1:0] high_time;

  // Handshakes: the result register frees itself when taken.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid     = out_valid_q;
  assign out_o.drive_low = out_q.drive_low;
  assign out_o.status    = out_q.status;
  assign out_o.rx_byte   = out_q.rx_byte;
  assign out_o.rx_valid  = out_q.rx_valid;

  // Timer counts down to zero and stays there.
  assign timer_dec  = (timer_q != '0) ? timer_q - TIMER_BITS'(1) : '0;
  assign timer_zero = (timer_dec == '0);

  // Next state and result for the current tick.
  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    shift_d     = shift_q;
    bit_count_d = bit_count_q;
    op_kind_d   = op_kind_q;
    last_d      = last_q;
    cmd_hold_d  = cmd_hold_q;
    cmd_stage_d = cmd_stage_q;

    res.drive_low = 1'b0;
    res.status    = ST_BUSY;
    res.rx_byte   = 8'h00;
    res.rx_valid  = 1'b0;

    ev_reset_done   = 1'b0;
    ev_wbit_done    = 1'b0;
    ev_rbit_done    = 1'b0;
    ev_byte_written = 1'b0;
    ev_start_write  = 1'b0;
    ev_load_write   = 1'b0;
    ev_finish       = 1'b0;
    start_byte      = in_i.tx_byte;
    fin_status      = ST_IDLE;
    high_time       = shift_q[0] ? cfg_q[CFG_WRITE_ONE_HIGH] : cfg_q[CFG_WRITE_ZERO_HIGH];

    case (phase_q)
      PH_IDLE: begin
        res.status = ST_IDLE;
        case (req_e'(in_i.req_type))
          REQ_RESET, REQ_BCAST: begin
            res.status = ST_BUSY;
            if (in_i.req_type == REQ_BCAST) begin
              op_kind_d   = OP_BCAST;
              cmd_hold_d  = in_i.tx_byte;
              cmd_stage_d = CMD_RESET;
            end else begin
              op_kind_d = OP_RESET;
            end
            // The request tick doubles as the pullup check.
            if (!in_i.line_level) begin
              ev_finish  = 1'b1;
              fin_status = ST_NO_PULLUP;
            end else begin
              phase_d = PH_RST_LOW;
              timer_d = TIMER_BITS'(at_least_one(cfg_q[CFG_RESET_LOW]));
            end
          end
          REQ_WRITE: begin
            res.status     = ST_BUSY;
            op_kind_d      = OP_WRITE;
            last_d         = in_i.last_byte;
            ev_start_write = 1'b1;
            start_byte     = in_i.tx_byte;
          end
          REQ_READ: begin
            res.status  = ST_BUSY;
            op_kind_d   = OP_READ;
            last_d      = in_i.last_byte;
            shift_d     = 8'h00;
            bit_count_d = BITS_PER_BYTE;
            phase_d     = PH_R_LOW;
            timer_d     = READ_LOW_T;
          end
          default: ;
        endcase
      end
      PH_RST_LOW: begin
        res.drive_low = 1'b1;
        timer_d       = timer_dec;
        if (timer_zero) begin
          phase_d = PH_PRES;
          timer_d = TIMER_BITS'(at_least_one(cfg_q[CFG_PRESENCE_WIN]));
        end
      end
      PH_PRES: begin
        if (!in_i.line_level) begin
          phase_d = PH_REL_WAIT;
          timer_d = TIMER_BITS'(at_least_one(cfg_q[CFG_RELEASE_WAIT]));
        end else begin
          timer_d = timer_dec;
          if (timer_zero) begin
            ev_finish  = 1'b1;
            fin_status = ST_NO_DEVICE;
          end
        end
      end
      PH_REL_WAIT: begin
        timer_d = timer_dec;
        if (in_i.line_level) begin
          if (timer_zero) begin
            ev_reset_done = 1'b1;
          end else begin
            phase_d = PH_REL_HOLD;
          end
        end else if (timer_zero) begin
          ev_finish  = 1'b1;
          fin_status = ST_TIMEOUT;
        end
      end
      PH_REL_HOLD: begin
        timer_d = timer_dec;
        if (timer_zero) begin
          ev_reset_done = 1'b1;
        end
      end
      PH_W_LOW: begin
        res.drive_low = 1'b1;
        timer_d       = timer_dec;
        if (timer_zero) begin
          if (high_time != '0) begin
            phase_d = PH_W_HIGH;
            timer_d = TIMER_BITS'(high_time);
          end else begin
            ev_wbit_done = 1'b1;
          end
        end
      end
      PH_W_HIGH: begin
        timer_d = timer_dec;
        if (timer_zero) begin
          ev_wbit_done = 1'b1;
        end
      end
      PH_R_LOW: begin
        res.drive_low = 1'b1;
        timer_d       = timer_dec;
        if (timer_zero) begin
          phase_d = PH_R_WAIT;
          timer_d = READ_WAIT_T;
        end
      end
      PH_R_WAIT: begin
        timer_d = timer_dec;
        if (timer_zero) begin
          shift_d = {in_i.line_level, shift_q[7:1]};
          if (cfg_q[CFG_READ_RECOVERY] != '0) begin
            phase_d = PH_R_REC;
            timer_d = TIMER_BITS'(cfg_q[CFG_READ_RECOVERY]);
          end else begin
            ev_rbit_done = 1'b1;
          end
        end
      end
      PH_R_REC: begin
        timer_d = timer_dec;
        if (timer_zero) begin
          ev_rbit_done = 1'b1;
        end
      end
      default: begin
        ev_finish  = 1'b1;
        fin_status = ST_IDLE;
      end
    endcase

    // End of a write slot: shift out and count the bit.
    if (ev_wbit_done) begin
      shift_d = shift_d >> 1;
      if (bit_count_d <= 4'd1) begin
        bit_count_d     = 4'd0;
        ev_byte_written = 1'b1;
      end else begin
        bit_count_d   = bit_count_d - 4'd1;
        ev_load_write = 1'b1;
      end
    end

    // Reset sequence finished: a broadcast goes on with skip-ROM.
    if (ev_reset_done) begin
      if (op_kind_d == OP_BCAST) begin
        cmd_stage_d    = CMD_SKIP;
        ev_start_write = 1'b1;
        start_byte     = SKIP_ROM;
      end else begin
        ev_finish  = 1'b1;
        fin_status = ST_DONE;
      end
    end

    // A whole byte went out.
    if (ev_byte_written) begin
      if (op_kind_d == OP_BCAST) begin
        if (cmd_stage_d == CMD_SKIP) begin
          cmd_stage_d    = CMD_BYTE;
          ev_start_write = 1'b1;
          start_byte     = cmd_hold_d;
        end else begin
          ev_finish  = 1'b1;
          fin_status = ST_DONE;
        end
      end else begin
        ev_finish  = 1'b1;
        fin_status = last_d ? ST_DONE : ST_BYTE_DONE;
      end
    end

    if (ev_start_write) begin
      shift_d       = start_byte;
      bit_count_d   = BITS_PER_BYTE;
      ev_load_write = 1'b1;
    end

    // Start a write slot with the low time of the next bit.
    if (ev_load_write) begin
      phase_d = PH_W_LOW;
      timer_d = TIMER_BITS'(at_least_one(shift_d[0] ? cfg_q[CFG_WRITE_ONE_LOW]
                                                    : cfg_q[CFG_WRITE_ZERO_LOW]));
    end

    // End of a read slot: deliver the byte after the eighth bit.
    if (ev_rbit_done) begin
      if (bit_count_d <= 4'd1) begin
        bit_count_d  = 4'd0;
        res.rx_byte  = shift_d;
        res.rx_valid = 1'b1;
        ev_finish    = 1'b1;
        fin_status   = last_d ? ST_DONE : ST_BYTE_DONE;
      end else begin
        bit_count_d = bit_count_d - 4'd1;
        phase_d     = PH_R_LOW;
        timer_d     = READ_LOW_T;
      end
    end

    if (ev_finish) begin
      res.status  = fin_status;
      phase_d     = PH_IDLE;
      timer_d     = '0;
      cmd_stage_d = CMD_RESET;
      op_kind_d   = OP_NONE;
    end
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      shift_q     <= 8'h00;
      bit_count_q <= 4'd0;
      op_kind_q   <= OP_NONE;
      last_q      <= 1'b0;
      cmd_hold_q  <= 8'h00;
      cmd_stage_q <= CMD_RESET;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      shift_q     <= shift_d;
      bit_count_q <= bit_count_d;
      op_kind_q   <= op_kind_d;
      last_q      <= last_d;
      cmd_hold_q  <= cmd_hold_d;
      cmd_stage_q <= cmd_stage_d;
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

  // Timing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_q[i] <= CFG_RESET_VAL[i];
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // A read byte is only delivered together with a completion status.
  `OWM_ASSERT(a_rx_with_done, clk_i, rst_ni,
    (out_valid_q && out_q.rx_valid) |->
      (out_q.status == ST_DONE || out_q.status == ST_BYTE_DONE), "rx beat without done status")
  // An idle tick never pulls the line low.
  `OWM_ASSERT(a_idle_released, clk_i, rst_ni,
    (in_acc && phase_q == PH_IDLE) |=> !out_q.drive_low, "line driven on an idle tick")
  // Write slots always have bits left to send.
  `OWM_NEVER(a_write_bits, clk_i, rst_ni,
    (phase_q == PH_W_LOW || phase_q == PH_W_HIGH) && bit_count_q == 4'd0,
    "write slot with no bits left")
  // The idle phase carries no operation.
  `OWM_ASSERT(a_idle_no_op, clk_i, rst_ni,
    (phase_q == PH_IDLE) |-> (op_kind_q == OP_NONE && cmd_stage_q == CMD_RESET),
    "operation left over in idle")

endmodule
`default_nettype wire

// File: bench/tb_onewire_bus_master.sv
// Self-checking testbench for the 1-Wire bus master: tick stimulus, timing setups, result checks.
`default_nettype none
module tb_onewire_bus_master;
  timeunit 1ns;
  timeprecision 1ps;
  import owm_pkg::*;

  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned MAX_PRINTS = 40;
  localparam int TMR_W = TIMER_BITS_DEF;

  // Request codes the block does not know; they behave like a plain tick.
  localparam logic [2:0] REQ_BAD_LO = 3'd5;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;

  // Sequencer phases tracked by the predictor.
  typedef enum logic [4:0] {
    SQ_IDLE, SQ_RST_LOW, SQ_PRES, SQ_REL_WAIT, SQ_REL_HOLD,
    SQ_W_LOW, SQ_W_HIGH, SQ_R_LOW, SQ_R_WAIT, SQ_R_REC
  } seq_phase_e;

  // How the emulated slave answers on the line during a reset.
  typedef enum {LN_GOOD, LN_NO_PULLUP, LN_NO_DEVICE, LN_TIMEOUT, LN_NOISE} line_mode_e;

  typedef struct packed {
    logic [2:0] req;
    logic       line;
    logic [7:0] tx;
    logic       last;
  } tick_t;

  // Bus-timing predictor plus the queue of expected result beats.
  class owm_scoreboard;
    logic [CFG_W-1:0] dur [CFG_NUM];
    seq_phase_e       phase;
    logic [TMR_W-1:0] timer;
    logic [7:0]       shreg;
    logic [3:0]       bits_left;
    op_e              op;
    logic             last_flag;
    logic [7:0]       cmd_byte;
    cmd_stage_e       stage;
    out_item_t        res;
    out_item_t        expq [$];
    int unsigned      n_fail;
    int unsigned      n_checked;
    int unsigned      status_seen [8];

    function new();
      dur = CFG_RESET_VAL;
      phase = SQ_IDLE;
      timer = '0;
      shreg = '0;
      bits_left = '0;
      op = OP_NONE;
      last_flag = 1'b0;
      cmd_byte = '0;
      stage = CMD_RESET;
      n_fail = 0;
      n_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_duration(cfg_idx_e idx, logic [CFG_W-1:0] v);
      dur[idx] = v;
    endfunction

    // Durations that need at least one tick.
    function logic [TMR_W-1:0] nonzero(logic [CFG_W-1:0] v);
      return (v == '0) ? TMR_W'(1) : TMR_W'(v);
    endfunction

    function void tick_down();
      if (timer != '0) timer = timer - 1'b1;
    endfunction

    function void finish_op(status_e s);
      res.status = s;
      phase = SQ_IDLE;
      timer = '0;
      stage = CMD_RESET;
      op = OP_NONE;
    endfunction

    function void load_write_bit();
      phase = SQ_W_LOW;
      timer = nonzero(shreg[0] ? dur[CFG_WRITE_ONE_LOW] : dur[CFG_WRITE_ZERO_LOW]);
    endfunction

    function void load_read_bit();
      phase = SQ_R_LOW;
      timer = nonzero(CFG_W'(READ_LOW_US_DEF));
    endfunction

    function void start_write(logic [7:0] b);
      shreg = b;
      bits_left = BITS_PER_BYTE;
      load_write_bit();
    endfunction

    // A low line on the request tick means nothing pulls the bus up.
    function void start_reset(logic line);
      if (!line) begin
        finish_op(ST_NO_PULLUP);
      end else begin
        phase = SQ_RST_LOW;
        timer = nonzero(dur[CFG_RESET_LOW]);
      end
    endfunction

    function void reset_done();
      if (op == OP_BCAST) begin
        stage = CMD_SKIP;
        start_write(SKIP_ROM);
      end else begin
        finish_op(ST_DONE);
      end
    endfunction

    function void byte_written();
      if (op == OP_BCAST) begin
        if (stage == CMD_SKIP) begin
          stage = CMD_BYTE;
          start_write(cmd_byte);
        end else begin
          finish_op(ST_DONE);
        end
      end else begin
        finish_op(last_flag ? ST_DONE : ST_BYTE_DONE);
      end
    endfunction

    function void write_bit_done();
      shreg = shreg >> 1;
      if (bits_left <= 4'd1) begin
        bits_left = '0;
        byte_written();
      end else begin
        bits_left = bits_left - 1'b1;
        load_write_bit();
      end
    endfunction

    function void read_bit_done();
      if (bits_left <= 4'd1) begin
        bits_left = '0;
        res.rx_byte = shreg;
        res.rx_valid = 1'b1;
        finish_op(last_flag ? ST_DONE : ST_BYTE_DONE);
      end else begin
        bits_left = bits_left - 1'b1;
        load_read_bit();
      end
    endfunction

    // Advance one microsecond tick and queue the result beat it produces.
    function void note_tick(tick_t t);
      logic [CFG_W-1:0] high_time;
      res = '0;
      res.status = ST_BUSY;
      case (phase)
        SQ_IDLE: begin
          res.status = ST_IDLE;
          case (t.req)
            REQ_RESET: begin
              op = OP_RESET;
              res.status = ST_BUSY;
              start_reset(t.line);
            end
            REQ_WRITE: begin
              op = OP_WRITE;
              last_flag = t.last;
              res.status = ST_BUSY;
              start_write(t.tx);
            end
            REQ_READ: begin
              op = OP_READ;
              last_flag = t.last;
              res.status = ST_BUSY;
              shreg = '0;
              bits_left = BITS_PER_BYTE;
              load_read_bit();
            end
            REQ_BCAST: begin
              op = OP_BCAST;
              cmd_byte = t.tx;
              stage = CMD_RESET;
              res.status = ST_BUSY;
              start_reset(t.line);
            end
            default: ;
          endcase
        end
        SQ_RST_LOW: begin
          res.drive_low = 1'b1;
          tick_down();
          if (timer == '0) begin
            phase = SQ_PRES;
            timer = nonzero(dur[CFG_PRESENCE_WIN]);
          end
        end
        // Any low sample inside the window is a presence pulse.
        SQ_PRES: begin
          if (!t.line) begin
            phase = SQ_REL_WAIT;
            timer = nonzero(dur[CFG_RELEASE_WAIT]);
          end else begin
            tick_down();
            if (timer == '0) finish_op(ST_NO_DEVICE);
          end
        end
        SQ_REL_WAIT: begin
          tick_down();
          if (t.line) begin
            if (timer == '0) reset_done();
            else phase = SQ_REL_HOLD;
          end else if (timer == '0) begin
            finish_op(ST_TIMEOUT);
          end
        end
        SQ_REL_HOLD: begin
          tick_down();
          if (timer == '0) reset_done();
        end
        SQ_W_LOW: begin
          res.drive_low = 1'b1;
          tick_down();
          if (timer == '0) begin
            high_time = shreg[0] ? dur[CFG_WRITE_ONE_HIGH] : dur[CFG_WRITE_ZERO_HIGH];
            if (high_time != '0) begin
              phase = SQ_W_HIGH;
              timer = TMR_W'(high_time);
            end else begin
              write_bit_done();
            end
          end
        end
        SQ_W_HIGH: begin
          tick_down();
          if (timer == '0) write_bit_done();
        end
        SQ_R_LOW: begin
          res.drive_low = 1'b1;
          tick_down();
          if (timer == '0) begin
            phase = SQ_R_WAIT;
            timer = TMR_W'(READ_SAMPLE_US_DEF + 1);
          end
        end
        // Bits arrive LSB first, so each sample enters at the top.
        SQ_R_WAIT: begin
          tick_down();
          if (timer == '0) begin
            shreg = {t.line, shreg[7:1]};
            if (dur[CFG_READ_RECOVERY] != '0) begin
              phase = SQ_R_REC;
              timer = TMR_W'(dur[CFG_READ_RECOVERY]);
            end else begin
              read_bit_done();
            end
          end
        end
        SQ_R_REC: begin
          tick_down();
          if (timer == '0) read_bit_done();
        end
        default: finish_op(ST_IDLE);
      endcase
      status_seen[res.status]++;
      expq.push_back(res);
    endfunction

    task report(string msg);
      n_fail++;
      if (n_fail <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    // Compare one result beat against the oldest expectation.
    task check_result(out_item_t got);
      out_item_t want;
      if (expq.size() == 0) begin
        report($sformatf("result beat with nothing expected (status %0d)", got.status));
        return;
      end
      want = expq.pop_front();
      n_checked++;
      if (got.drive_low !== want.drive_low)
        report($sformatf("beat %0d drive_low %b, want %b", n_checked, got.drive_low,
                         want.drive_low));
      if (got.status !== want.status)
        report($sformatf("beat %0d status %0d, want %0d", n_checked, got.status, want.status));
      if (got.rx_byte !== want.rx_byte)
        report($sformatf("beat %0d rx_byte %h, want %h", n_checked, got.rx_byte, want.rx_byte));
      if (got.rx_valid !== want.rx_valid)
        report($sformatf("beat %0d rx_valid %b, want %b", n_checked, got.rx_valid,
                         want.rx_valid));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  owm_in_if  in_if ();
  owm_out_if out_if ();
  owm_cfg_if cfg_if ();

  onewire_bus_master u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  owm_scoreboard    sb;
  logic [CFG_W-1:0] timing [CFG_NUM];
  int unsigned      send_idle;
  int unsigned      recv_idle;
  logic             hold_go = 1'b0;
  int unsigned      n_ticks = 0;
  int unsigned      n_settings = 1;
  int unsigned      op_count [8];
  int unsigned      cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check accepted beats, then pick the next ready level.
  initial begin : result_sink
    int unsigned hold_left;
    out_item_t   got;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.drive_low = out_if.drive_low;
        got.status = out_if.status;
        got.rx_byte = out_if.rx_byte;
        got.rx_valid = out_if.rx_valid;
        sb.check_result(got);
      end
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Line level the emulated slave shows for the tick about to be sent.
  function automatic logic line_for(line_mode_e mode);
    case (sb.phase)
      SQ_IDLE:
        return (mode == LN_NO_PULLUP) ? 1'b0 : (mode == LN_NOISE) ? 1'($urandom_range(1)) : 1'b1;
      SQ_PRES: begin
        if (mode == LN_NO_DEVICE) return 1'b1;
        if (mode == LN_TIMEOUT) return 1'b0;
        if (mode == LN_GOOD) return ($urandom_range(2) != 0) ? 1'b1 : 1'b0;
        return 1'($urandom_range(1));
      end
      SQ_REL_WAIT: begin
        if (mode == LN_TIMEOUT) return 1'b0;
        if (mode == LN_NO_DEVICE) return 1'b1;
        if (mode == LN_GOOD) return ($urandom_range(3) != 0);
        return 1'($urandom_range(1));
      end
      default: return 1'($urandom_range(1));
    endcase
  endfunction

  // Offer one tick beat, with random gaps, until the block takes it.
  task automatic send_tick(logic [2:0] req, logic line, logic [7:0] tx, logic last);
    tick_t t;
    t = '{req: req, line: line, tx: tx, last: last};
    if ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= t.req;
    in_if.line_level <= t.line;
    in_if.tx_byte <= t.tx;
    in_if.last_byte <= t.last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_tick(t);
    n_ticks++;
  endtask

  // One request, then ticks until the sequencer is idle again; busy ticks
  // sometimes carry a stray request that must be ignored.
  task automatic run_op(logic [2:0] req, logic [7:0] tx, logic last, line_mode_e mode);
    logic [2:0] stray;
    op_count[req]++;
    send_tick(req, line_for(mode), tx, last);
    while (sb.phase != SQ_IDLE) begin
      stray = ($urandom_range(19) == 0) ? 3'($urandom_range(REQ_BAD_HI, REQ_RESET)) : REQ_NONE;
      send_tick(stray, line_for(mode), 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // Stop offering ticks until every expected beat has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expq.size() != 0);
  endtask

  // Write all timing registers with the block idle.
  task automatic apply_timing();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_idx_e'(i);
      cfg_if.data <= timing[i];
      do @(posedge clk); while (!cfg_if.ready);
      sb.set_duration(cfg_idx_e'(i), timing[i]);
    end
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // Mostly well-formed transactions with random content, some broken resets.
  task automatic random_ops(int unsigned n, bit with_hold, bit with_pause);
    int unsigned start;
    int unsigned pick;
    line_mode_e  mode;
    logic [2:0]  filler;
    start = n_ticks;
    if (with_hold) hold_go = 1'b1;
    while (n_ticks - start < n) begin
      repeat ($urandom_range(2)) begin
        filler = ($urandom_range(3) == 0) ? 3'($urandom_range(REQ_BAD_HI, REQ_BAD_LO)) : REQ_NONE;
        send_tick(filler, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
      end
      pick = $urandom_range(99);
      mode = (pick < 65) ? LN_GOOD : (pick < 75) ? LN_NO_PULLUP : (pick < 83) ? LN_NO_DEVICE :
             (pick < 90) ? LN_TIMEOUT : LN_NOISE;
      run_op(3'($urandom_range(REQ_BCAST, REQ_RESET)), 8'($urandom), 1'($urandom_range(1)),
             mode);
      if (with_pause) begin
        with_pause = 1'b0;
        drain_results();
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    foreach (op_count[i]) op_count[i] = 0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_NONE;
    in_if.line_level = 1'b1;
    in_if.tx_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_RESET_LOW;
    cfg_if.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles rarely, receiver often; one write on the default timing with a long stall.
    send_idle = 18;
    recv_idle = 59;
    hold_go = 1'b1;
    run_op(REQ_WRITE, 8'hA6, 1'b1, LN_GOOD);

    // Directed corner cases on short timing.
    timing = '{10'd3, 10'd2, 10'd3, 10'd1, 10'd2, 10'd3, 10'd1, 10'd2};
    apply_timing();
    run_op(REQ_RESET, 8'h00, 1'b0, LN_GOOD);
    run_op(REQ_RESET, 8'h00, 1'b0, LN_NO_PULLUP);
    run_op(REQ_RESET, 8'h00, 1'b0, LN_NO_DEVICE);
    run_op(REQ_RESET, 8'h00, 1'b0, LN_TIMEOUT);
    run_op(REQ_WRITE, 8'h00, 1'b0, LN_GOOD);
    run_op(REQ_WRITE, 8'hFF, 1'b1, LN_GOOD);
    run_op(REQ_READ, 8'h00, 1'b0, LN_NOISE);
    run_op(REQ_READ, 8'hFF, 1'b1, LN_NOISE);
    run_op(REQ_BCAST, 8'h33, 1'b0, LN_GOOD);
    run_op(REQ_BCAST, 8'hF0, 1'b1, LN_NO_PULLUP);
    run_op(REQ_BCAST, 8'h0F, 1'b0, LN_NO_DEVICE);
    run_op(REQ_BCAST, 8'hA5, 1'b1, LN_TIMEOUT);
    for (int c = REQ_BAD_LO; c <= REQ_BAD_HI; c++) send_tick(3'(c), 1'b0, 8'hFF, 1'b1);
    random_ops(150, 1'b1, 1'b1);

    // Swap the idle rates; shortest timing with zero high and recovery times.
    send_idle = 59;
    recv_idle = 18;
    timing = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd0, 10'd1, 10'd0, 10'd0};
    apply_timing();
    random_ops(150, 1'b0, 1'b0);
    timing = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
    apply_timing();
    random_ops(100, 1'b0, 1'b0);
    foreach (timing[i]) timing[i] = CFG_W'($urandom_range(12));
    apply_timing();
    random_ops(120, 1'b1, 1'b0);

    // No idling at all; uneven timing.
    send_idle = 0;
    recv_idle = 0;
    timing = '{10'd5, 10'd4, 10'd6, 10'd2, 10'd7, 10'd9, 10'd3, 10'd4};
    apply_timing();
    random_ops(100, 1'b0, 1'b0);

    // Let the last results arrive, then make sure nothing extra shows up.
    in_if.valid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.expq.size() != 0) sb.report($sformatf("%0d results never arrived", sb.expq.size()));

    $display("summary: %0d ticks, %0d results checked, %0d timing setups",
             n_ticks, sb.n_checked, n_settings);
    $display("summary: %0d reset %0d write %0d read %0d bcast, pullup/device/timeout %0d/%0d/%0d",
             op_count[REQ_RESET], op_count[REQ_WRITE], op_count[REQ_READ], op_count[REQ_BCAST],
             sb.status_seen[ST_NO_PULLUP], sb.status_seen[ST_NO_DEVICE],
             sb.status_seen[ST_TIMEOUT]);
    if (sb.n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
